// ===== hdl/cc2a_pkg.sv =====
`timescale 1ns / 1ps

package cc2a_pkg;

  // Markers held in the lookup table besides plain characters
  localparam logic [7:0] CODE_NONE = 8'hFF;
  localparam logic [7:0] CODE_LCS  = 8'hFE;
  localparam logic [7:0] CODE_UCS  = 8'hFD;

  localparam logic [7:0] ASCII_NL  = 8'h0A;
  localparam logic [7:0] ASCII_TAB = 8'h09;
  localparam logic [7:0] ASCII_BS  = 8'h08;
  localparam logic [7:0] ASCII_GRV = 8'h60;

  // Longest run of newlines passed on before further ones are dropped
  localparam logic [1:0] NL_RUN_MAX = 2'd2;

  localparam int unsigned CHAR_W = 7;

  // Concise code to ASCII; upper half is the upper-case shift page
  localparam logic [7:0] CodeTable [128] = '{
    " ", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", CODE_NONE, CODE_NONE, CODE_NONE, CODE_NONE, CODE_NONE, CODE_NONE,
    "0", "/", "s", "t", "u", "v", "w", "x",
    "y", "z", CODE_NONE, ",", CODE_NONE, CODE_NONE, ASCII_TAB, CODE_NONE,
    "@", "j", "k", "l", "m", "n", "o", "p",
    "q", "r", CODE_NONE, CODE_NONE, "-", ")", ASCII_GRV, "(",
    CODE_NONE, "a", "b", "c", "d", "e", "f", "g",
    "h", "i", CODE_LCS, ".", CODE_UCS, ASCII_BS, CODE_NONE, ASCII_NL,

    " ", "\"", "'", "~", "#", "!", "&", "<",
    ">", "^", CODE_NONE, CODE_NONE, CODE_NONE, CODE_NONE, CODE_NONE, CODE_NONE,
    "\\", "?", "S", "T", "U", "V", "W", "X",
    "Y", "Z", CODE_NONE, "=", CODE_NONE, CODE_NONE, ASCII_TAB, CODE_NONE,
    "_", "J", "K", "L", "M", "N", "O", "P",
    "Q", "R", CODE_NONE, CODE_NONE, "+", "]", "|", "[",
    CODE_NONE, "A", "B", "C", "D", "E", "F", "G",
    "H", "I", CODE_LCS, "*", CODE_UCS, ASCII_BS, CODE_NONE, ASCII_NL
  };

  // Outcome of decoding one tape byte against the current state
  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] ascii_char;
    logic              upper_shift;
    logic [1:0]        newline_run;
  } cc2a_dec_t;

endpackage

// ===== hdl/cc2a_decode.sv =====
`timescale 1ns / 1ps

module cc2a_decode
  import cc2a_pkg::*;
(
  input  logic [7:0] tape_byte_i,
  input  logic       upper_shift_i,
  input  logic [1:0] newline_run_i,
  output cc2a_dec_t  dec_o
);

  logic       skip;
  logic [6:0] idx;
  logic [7:0] code;

  // Feed bytes and bytes with bit 6 set carry nothing
  assign skip = (tape_byte_i == 8'd0) || tape_byte_i[6];
  assign idx  = {upper_shift_i, tape_byte_i[5:0]};
  assign code = CodeTable[idx];

  // Resolve shifts, unmapped codes and newline runs
  always_comb begin
    dec_o.emit        = 1'b0;
    dec_o.ascii_char  = code[CHAR_W-1:0];
    dec_o.upper_shift = upper_shift_i;
    dec_o.newline_run = newline_run_i;
    if (!skip) begin
      if (code == CODE_LCS) begin
        dec_o.upper_shift = 1'b0;
      end else if (code == CODE_UCS) begin
        dec_o.upper_shift = 1'b1;
      end else if (code == ASCII_NL) begin
        if (newline_run_i < NL_RUN_MAX) begin
          dec_o.emit        = 1'b1;
          dec_o.newline_run = newline_run_i + 2'd1;
        end
      end else if (code != CODE_NONE) begin
        dec_o.emit        = 1'b1;
        dec_o.newline_run = 2'd0;
      end
    end
  end

endmodule

// ===== hdl/concise_code_to_ascii_decoder_top.sv =====
`timescale 1ns / 1ps

// Concise-code tape to ASCII decoder. Each input beat is one raw tape byte;
// each output beat is one ASCII character. Feed bytes, bytes with bit 6 set,
// shift codes, unmapped codes and newlines beyond two in a row produce no
// output beat. A byte passes through an input register, one table lookup
// with the shift and newline-run update, and an output register. One
// byte per cycle is sustained as long as the output side keeps taking
// beats. The shift state is applied in the lookup stage, so consecutive
// bytes see each other's shift changes without a bubble.

module concise_code_to_ascii_decoder_top
  import cc2a_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] tape_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [6:0] ascii_char, [7] zero
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q;
  logic              upper_shift_q, upper_shift_d;
  logic [1:0]        newline_run_q, newline_run_d;
  logic              advance;
  logic              in_take;
  cc2a_dec_t         dec;

  cc2a_decode u_decode (
    .tape_byte_i   (in_byte_q),
    .upper_shift_i (upper_shift_q),
    .newline_run_i (newline_run_q),
    .dec_o         (dec)
  );

  // Move the held byte on when the output register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d    = in_valid_q;
    out_valid_d   = out_valid_q;
    upper_shift_d = upper_shift_q;
    newline_run_d = newline_run_q;
    if (advance) begin
      out_valid_d = in_valid_q && dec.emit;
      in_valid_d  = in_take;
      if (in_valid_q) begin
        upper_shift_d = dec.upper_shift;
        newline_run_d = dec.newline_run;
      end
    end else if (in_take) begin
      in_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      upper_shift_q <= 1'b0;
      newline_run_q <= 2'd0;
    end else begin
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      upper_shift_q <= upper_shift_d;
      newline_run_q <= newline_run_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && in_valid_q && dec.emit) begin
      out_char_q <= dec.ascii_char;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};

  // The newline run never passes its limit
  a_run_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    newline_run_q <= NL_RUN_MAX)
    else $error("newline run count out of range");

  // A newline waiting at the output has been counted in the run
  a_nl_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata == ASCII_NL)) |-> (newline_run_q != 2'd0))
    else $error("emitted newline not counted");

  // Input is held off only while a byte waits behind a stalled output
  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule

// ===== sim/tb_concise_code_to_ascii_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_concise_code_to_ascii_decoder_top;
  import cc2a_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Concise codes that steer the decoder state
  localparam logic [5:0] CC_LOWER_SHIFT = 6'o72;
  localparam logic [5:0] CC_UPPER_SHIFT = 6'o74;
  localparam logic [5:0] CC_NEWLINE = 6'o77;

  // Table markers and control characters
  localparam logic [7:0] MAP_NONE = 8'hFF;
  localparam logic [7:0] MAP_LOWER = 8'hFE;
  localparam logic [7:0] MAP_UPPER = 8'hFD;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_GRAVE = 8'h60;

  // Index is {upper page, six-bit concise code}
  localparam logic [7:0] ConciseMap [128] = '{
    " ", "1", "2", "3", "4", "5", "6", "7",
    "8", "9", MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE,
    "0", "/", "s", "t", "u", "v", "w", "x",
    "y", "z", MAP_NONE, ",", MAP_NONE, MAP_NONE, CH_TAB, MAP_NONE,
    "@", "j", "k", "l", "m", "n", "o", "p",
    "q", "r", MAP_NONE, MAP_NONE, "-", ")", CH_GRAVE, "(",
    MAP_NONE, "a", "b", "c", "d", "e", "f", "g",
    "h", "i", MAP_LOWER, ".", MAP_UPPER, CH_BS, MAP_NONE, CH_NL,

    " ", "\"", "'", "~", "#", "!", "&", "<",
    ">", "^", MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE, MAP_NONE,
    "\\", "?", "S", "T", "U", "V", "W", "X",
    "Y", "Z", MAP_NONE, "=", MAP_NONE, MAP_NONE, CH_TAB, MAP_NONE,
    "_", "J", "K", "L", "M", "N", "O", "P",
    "Q", "R", MAP_NONE, MAP_NONE, "+", "]", "|", "[",
    MAP_NONE, "A", "B", "C", "D", "E", "F", "G",
    "H", "I", MAP_LOWER, "*", MAP_UPPER, CH_BS, MAP_NONE, CH_NL
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] tape_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [6:0] ascii_char, [7] zero

  // Bytes waiting to be sent and characters waiting to arrive
  logic [7:0]        tape_q [$];
  logic [CHAR_W-1:0] ascii_due_q [$];

  // Decoder state as the predictor sees it
  logic       upper_page = 1'b0;
  logic [1:0] nl_streak = 2'd0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_cnt = 0;
  int unsigned bytes_taken = 0;
  int unsigned chars_seen = 0;
  int unsigned bytes_skipped = 0;
  int unsigned shift_cnt = 0;
  int unsigned nl_dropped = 0;
  int unsigned quiet_cycles = 0;

  concise_code_to_ascii_decoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Work out the character one tape byte yields, if any, and update state
  function automatic void decode_tape_byte(input logic [7:0] tape_byte);
    logic [7:0] mapped;
    mapped = ConciseMap[{upper_page, tape_byte[5:0]}];
    if (tape_byte == 8'h00 || tape_byte[6] || mapped == MAP_NONE) begin
      bytes_skipped++;
    end else if (mapped == MAP_LOWER || mapped == MAP_UPPER) begin
      upper_page = (mapped == MAP_UPPER);
      shift_cnt++;
    end else if (mapped == CH_NL && nl_streak >= NL_RUN_MAX) begin
      nl_dropped++;
    end else begin
      nl_streak = (mapped == CH_NL) ? nl_streak + 2'd1 : 2'd0;
      ascii_due_q.push_back(mapped[CHAR_W-1:0]);
    end
  endfunction

  // Present the next tape byte once the previous beat has gone
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tape_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tape_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Throttle the output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on every input beat, check every output beat
  always @(posedge clk_i) begin
    logic [CHAR_W-1:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        decode_tape_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        chars_seen++;
        if (ascii_due_q.size() == 0) begin
          $error("unexpected output beat: ascii_char actual %h", m_axis_tdata[6:0]);
          error_cnt++;
        end else begin
          want = ascii_due_q.pop_front();
          if (m_axis_tdata[6:0] !== want) begin
            $error("ascii_char: expected %h, actual %h", want, m_axis_tdata[6:0]);
            error_cnt++;
          end
          if (m_axis_tdata[7] !== 1'b0) begin
            $error("tdata pad bit: expected 0, actual %b", m_axis_tdata[7]);
            error_cnt++;
          end
        end
      end
    end
  end

  // Abort when neither side moves a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_concise_code_to_ascii_decoder_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Mostly well-formed text with shifts and blank-line runs, some raw noise
  task automatic queue_random_bytes(input int unsigned n);
    int unsigned left;
    int unsigned pick;
    int unsigned burst;
    logic [7:0]  b;
    left = n;
    while (left != 0) begin
      pick = $urandom_range(99);
      b = 8'($urandom_range(255));
      b[6] = 1'b0;
      if (pick < 55) begin
        tape_q.push_back(b);
        left--;
      end else if (pick < 70) begin
        b[5:0] = $urandom_range(1) ? CC_UPPER_SHIFT : CC_LOWER_SHIFT;
        tape_q.push_back(b);
        left--;
      end else if (pick < 85) begin
        burst = $urandom_range(4, 1);
        while (burst != 0 && left != 0) begin
          b[7] = 1'($urandom_range(1));
          b[5:0] = CC_NEWLINE;
          tape_q.push_back(b);
          burst--;
          left--;
        end
      end else begin
        tape_q.push_back(8'($urandom_range(255)));
        left--;
      end
    end
  endtask

  // Send one batch under the given idling and wait until it has drained
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_bytes(n);
    while (tape_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (ascii_due_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: feed, bit 6 set, bit 7 set, shifts, unmapped codes,
    // control characters and newline runs cut at two
    tape_q.push_back(8'h00);
    tape_q.push_back(8'h40);
    tape_q.push_back(8'hFF);
    tape_q.push_back(8'h80);
    tape_q.push_back(8'h01);
    tape_q.push_back(8'h0A);
    tape_q.push_back({2'b00, CC_UPPER_SHIFT});
    tape_q.push_back(8'h21);
    tape_q.push_back(8'hBB);
    tape_q.push_back(8'h00);
    tape_q.push_back(8'h21);
    tape_q.push_back({2'b00, CC_NEWLINE});
    tape_q.push_back({2'b10, CC_NEWLINE});
    tape_q.push_back({2'b00, CC_NEWLINE});
    tape_q.push_back({2'b10, CC_LOWER_SHIFT});
    tape_q.push_back({2'b00, CC_NEWLINE});
    tape_q.push_back(8'h11);
    tape_q.push_back({2'b00, CC_NEWLINE});
    tape_q.push_back(8'h3D);
    tape_q.push_back(8'h1E);
    tape_q.push_back(8'h2E);
    tape_q.push_back(8'h30);
    tape_q.push_back(8'h3F);
    tape_q.push_back(8'h3F);
    tape_q.push_back(8'h3F);

    run_phase(0, 0, 270);
    run_phase(82, 0, 270);
    run_phase(0, 82, 270);
    run_phase(38, 38, 270);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (ascii_due_q.size() != 0) begin
      $error("%0d expected characters never arrived", ascii_due_q.size());
      error_cnt++;
    end

    $display("Sent %0d tape bytes (%0d skipped, %0d shift codes, %0d newlines cut),",
             bytes_taken, bytes_skipped, shift_cnt, nl_dropped);
    $display("checked %0d characters under four idling mixes.", chars_seen);
    if (error_cnt == 0) begin
      $display("tb_concise_code_to_ascii_decoder_top: done, clean");
    end else begin
      $display("tb_concise_code_to_ascii_decoder_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cc2a_pkg.sv
hdl/cc2a_decode.sv
hdl/concise_code_to_ascii_decoder_top.sv
sim/tb_concise_code_to_ascii_decoder_top.sv
